// ===== sv/ptli_pkg.sv =====
// ----------------------------------------------------------------------------
// ptli_pkg
// Shared types, widths and codes of the polar table interpolator.
// ----------------------------------------------------------------------------
package ptli_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int CFG_WIDTH   = 7;
    localparam int INDEX_WIDTH = 6;

    localparam int IW      = $clog2(TABLE_DEPTH);
    localparam int NW      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = ANGLE_WIDTH + 2 * VALUE_WIDTH;
    localparam int NUM_W   = ANGLE_WIDTH + VALUE_WIDTH;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    // Request operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Clamp status codes
    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_FIRST = 2'd1,
        CLAMP_LAST  = 2'd2
    } t_clamp;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_FIN
    } t_state;

    // Divider request
    typedef struct packed {
        logic                   start;
        logic [NUM_W-1:0]       dividend;
        logic [ANGLE_WIDTH-1:0] divisor;
    } t_div_req;

endpackage

// ===== sv/ptli_ram.sv =====
// ----------------------------------------------------------------------------
// ptli_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ptli_div.sv =====
// ----------------------------------------------------------------------------
// ptli_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptli_div import ptli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_done;
    logic                   n_done;
    logic [NUM_W-1:0]       r_quo;
    logic [NUM_W-1:0]       n_quo;
    logic [ANGLE_WIDTH-1:0] r_rem;
    logic [ANGLE_WIDTH-1:0] n_rem;
    logic [ANGLE_WIDTH-1:0] r_den;
    logic [ANGLE_WIDTH-1:0] n_den;
    logic [ANGLE_WIDTH:0]   rem_shift;
    logic [ANGLE_WIDTH:0]   rem_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_shift = {r_rem, r_quo[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, r_den};
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_den     = r_den;
        if (i_req.start) begin
            n_cnt = CNT_W'(NUM_W);
            n_quo = i_req.dividend;
            n_rem = '0;
            n_den = i_req.divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!rem_diff[ANGLE_WIDTH]) begin
                n_rem = rem_diff[ANGLE_WIDTH-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[ANGLE_WIDTH-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/polar_table_linear_interpolator.sv =====
// Load request: written to the table when accepted, no result.
// Query request: a linear scan reads one entry per cycle; the first entry k
// whose angle is not below the query decides. When clamped, the entry goes
// through ST_FIN to the output register; else a multiply-divide pass for
// lift and one for drag run before ST_FIN. Requests: one at a time.
// Reset: synchronous active low; table_size returns to 1, table contents kept.
// ----------------------------------------------------------------------------
// polar_table_linear_interpolator
// Polar table lookup with lower-bound placement and linear interpolation.
// ----------------------------------------------------------------------------
module polar_table_linear_interpolator import ptli_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_WIDTH-1:0]          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [INDEX_WIDTH-1:0]        i_entry_index,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    input  logic signed [VALUE_WIDTH-1:0] i_lift_value,
    input  logic signed [VALUE_WIDTH-1:0] i_drag_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_lift,
    output logic signed [VALUE_WIDTH-1:0] o_drag,
    output logic [1:0]                    o_clamp_status
);

    t_state                 r_state, n_state;
    logic [CFG_WIDTH-1:0]   r_table_size;
    logic [ANGLE_WIDTH-1:0] r_q, n_q;
    logic [NW-1:0]          r_n, n_n;
    logic [NW-1:0]          r_ptr, n_ptr;
    logic                   r_dv, n_dv;
    logic [NW-1:0]          r_didx, n_didx;
    logic [ENTRY_W-1:0]     r_prev, n_prev;
    logic [ANGLE_WIDTH-1:0] r_dq, n_dq;
    logic [ANGLE_WIDTH-1:0] r_den, n_den;
    logic [VALUE_WIDTH-1:0] r_y1l, n_y1l, r_y1d, n_y1d;
    logic [VALUE_WIDTH-1:0] r_y2l, n_y2l, r_y2d, n_y2d;
    logic                   r_lane, n_lane;
    logic [NUM_W-1:0]       r_prod, n_prod;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_res_lift, n_res_lift;
    logic [VALUE_WIDTH-1:0] r_res_drag, n_res_drag;
    t_clamp                 r_status, n_status;
    logic                   r_o_valid, n_o_valid;
    logic [VALUE_WIDTH-1:0] r_o_lift, n_o_lift;
    logic [VALUE_WIDTH-1:0] r_o_drag, n_o_drag;
    t_clamp                 r_o_status, n_o_status;

    logic                   in_accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [ENTRY_W-1:0]     rd_data;
    logic [NW-1:0]          tbl_n;
    logic signed [ANGLE_WIDTH-1:0] rd_ang;
    logic signed [ANGLE_WIDTH-1:0] prev_ang;
    logic signed [ANGLE_WIDTH-1:0] q_ang;
    logic [VALUE_WIDTH-1:0] y1_sel, y2_sel;
    logic [VALUE_WIDTH:0]   dy;
    logic [VALUE_WIDTH-1:0] dy_mag;
    logic [VALUE_WIDTH-1:0] quo;
    logic [VALUE_WIDTH-1:0] interp;
    logic                   div_start;
    t_div_req               div_req;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quo;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign wr_en      = in_accept && (i_op == OP_LOAD)
                        && (32'(i_entry_index) < TABLE_DEPTH);

    // Effective table size: zero counts as one, large values saturate
    always_comb begin
        if (r_table_size == '0) begin
            tbl_n = NW'(1);
        end else if (32'(r_table_size) > TABLE_DEPTH) begin
            tbl_n = NW'(TABLE_DEPTH);
        end else begin
            tbl_n = NW'(r_table_size);
        end
    end

    ptli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IW'(i_entry_index)),
        .i_wr_data ({i_angle, i_lift_value, i_drag_value}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr[IW-1:0]),
        .o_rd_data (rd_data)
    );

    ptli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Lane operands and interpolation arithmetic
    assign rd_ang   = rd_data[ENTRY_W-1 -: ANGLE_WIDTH];
    assign prev_ang = r_prev[ENTRY_W-1 -: ANGLE_WIDTH];
    assign q_ang    = r_q;
    assign y1_sel   = r_lane ? r_y1d : r_y1l;
    assign y2_sel   = r_lane ? r_y2d : r_y2l;
    assign dy       = {y2_sel[VALUE_WIDTH-1], y2_sel} - {y1_sel[VALUE_WIDTH-1], y1_sel};
    assign dy_mag   = dy[VALUE_WIDTH] ? VALUE_WIDTH'(-dy) : dy[VALUE_WIDTH-1:0];
    assign quo      = div_quo[VALUE_WIDTH-1:0];
    assign interp   = y1_sel + (r_neg ? (~quo + 1'b1) : quo);

    assign div_req = '{start: div_start, dividend: r_prod, divisor: r_den};

    // Sequencer: next state and datapath
    always_comb begin
        n_state    = r_state;
        n_q        = r_q;
        n_n        = r_n;
        n_ptr      = r_ptr;
        n_dv       = 1'b0;
        n_didx     = r_didx;
        n_prev     = r_prev;
        n_dq       = r_dq;
        n_den      = r_den;
        n_y1l      = r_y1l;
        n_y1d      = r_y1d;
        n_y2l      = r_y2l;
        n_y2d      = r_y2d;
        n_lane     = r_lane;
        n_prod     = r_prod;
        n_neg      = r_neg;
        n_res_lift = r_res_lift;
        n_res_drag = r_res_drag;
        n_status   = r_status;
        n_o_valid  = r_o_valid;
        n_o_lift   = r_o_lift;
        n_o_drag   = r_o_drag;
        n_o_status = r_o_status;
        rd_en      = 1'b0;
        div_start  = 1'b0;

        // Drop the result once taken
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_op == OP_QUERY)) begin
                    n_q     = i_angle;
                    n_n     = tbl_n;
                    n_ptr   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next read
                if (r_ptr < r_n) begin
                    rd_en  = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_ptr;
                end
                // Check the entry read last cycle
                if (r_dv) begin
                    if (rd_ang >= q_ang) begin
                        if (r_didx == '0) begin
                            n_status   = CLAMP_FIRST;
                            n_res_lift = rd_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
                            n_res_drag = rd_data[VALUE_WIDTH-1:0];
                            n_state    = ST_FIN;
                        end else begin
                            n_status = CLAMP_NONE;
                            n_dq     = r_q - prev_ang;
                            n_den    = rd_ang - prev_ang;
                            n_y1l    = r_prev[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
                            n_y1d    = r_prev[VALUE_WIDTH-1:0];
                            n_y2l    = rd_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
                            n_y2d    = rd_data[VALUE_WIDTH-1:0];
                            n_lane   = 1'b0;
                            n_state  = ST_MUL;
                        end
                    end else begin
                        n_prev = rd_data;
                        if (r_didx == r_n - 1'b1) begin
                            n_status   = CLAMP_LAST;
                            n_res_lift = rd_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
                            n_res_drag = rd_data[VALUE_WIDTH-1:0];
                            n_state    = ST_FIN;
                        end
                    end
                end
            end
            ST_MUL: begin
                // Magnitude product; the sign of the slope rides alongside
                n_prod  = NUM_W'(r_dq) * NUM_W'(dy_mag);
                n_neg   = dy[VALUE_WIDTH];
                n_state = ST_DSTART;
            end
            ST_DSTART: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (!r_lane) begin
                        n_res_lift = interp;
                        n_lane     = 1'b1;
                        n_state    = ST_MUL;
                    end else begin
                        n_res_drag = interp;
                        n_state    = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_lift   = r_res_lift;
                    n_o_drag   = r_res_drag;
                    n_o_status = r_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_table_size <= CFG_WIDTH'(1);
            r_dv         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_n        <= n_n;
        r_ptr      <= n_ptr;
        r_didx     <= n_didx;
        r_prev     <= n_prev;
        r_dq       <= n_dq;
        r_den      <= n_den;
        r_y1l      <= n_y1l;
        r_y1d      <= n_y1d;
        r_y2l      <= n_y2l;
        r_y2d      <= n_y2d;
        r_lane     <= n_lane;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_res_lift <= n_res_lift;
        r_res_drag <= n_res_drag;
        r_status   <= n_status;
        r_o_lift   <= n_o_lift;
        r_o_drag   <= n_o_drag;
        r_o_status <= n_o_status;
    end

    assign o_out_valid    = r_o_valid;
    assign o_lift         = r_o_lift;
    assign o_drag         = r_o_drag;
    assign o_clamp_status = r_o_status;

endmodule

// ===== sv/ptli_checker.sv =====
// ----------------------------------------------------------------------------
// ptli_checker
// Port-level assertions for the polar table interpolator.
// ----------------------------------------------------------------------------
module ptli_checker import ptli_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_op,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_clamp_status
);

    // A stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A query request occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_QUERY) |=> !o_in_ready)
        else $error("ready right after a query request");

    // A load request does not take the block out of ready
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_LOAD) |=> o_in_ready)
        else $error("load request stalled the block");

    // No result can appear in the cycle right after a query request
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_QUERY) && !o_out_valid
        |=> !o_out_valid)
        else $error("result appeared too early");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_clamp_status == CLAMP_NONE) ||
                        (o_clamp_status == CLAMP_FIRST) ||
                        (o_clamp_status == CLAMP_LAST))
        else $error("undefined clamp status");

endmodule

bind polar_table_linear_interpolator ptli_checker u_ptli_checker (.*);
